>>> design/assert_macros.svh
// Assertion macros used by the bank controller RTL.
// Needs nothing else; include after the package import.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define CBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/cbc_pkg.sv
// Types and constants of the cartridge bank controller.
// No dependencies; every other design file except assert_macros.svh imports this package.
`default_nettype none

package cbc_pkg;

   localparam int ADDR_W = 16;
   localparam int DATA_W = 8;
   localparam int ROM_W  = 8;
   localparam int RAM_W  = 4;

   // RAM bank selects above this value pick the RTC window on MBC3
   localparam logic [DATA_W-1:0] MBC3_RAM_MAX = 8'h04;
   localparam logic [ROM_W-1:0]  ROM_RESET    = 8'h01;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_MBC1 = 2'd1,
      KIND_MBC3 = 2'd2,
      KIND_MBC5 = 2'd3
   } kind_type;

   // 8 KiB windows of the lower 32 KiB, picked by address bits 14:13
   typedef enum logic [1:0] {
      REG_ENABLE  = 2'd0,
      REG_ROM_SEL = 2'd1,
      REG_RAM_SEL = 2'd2,
      REG_MODE    = 2'd3
   } region_type;

   typedef struct packed {
      logic [ADDR_W-1:0] write_address;
      logic [DATA_W-1:0] write_data;
   } req_beat_type;

   typedef struct packed {
      logic [ROM_W-1:0] rom_bank;
      logic [RAM_W-1:0] ram_bank;
      logic             rtc_selected;
      logic             rom_bank_changed;
      logic             ram_bank_changed;
      logic             save_old_ram;
      logic [RAM_W-1:0] old_ram_bank;
   } rsp_beat_type;

   typedef struct packed {
      logic             banking_mode;
      logic [1:0]       upper_rom_bits;
      logic [ROM_W-1:0] current_rom;
      logic [RAM_W-1:0] current_ram;
      logic             rtc_flag;
   } bank_state_type;

endpackage

`default_nettype wire

>>> design/cbc_req_if.sv
// Request channel: one CPU write beat with valid/ready handshake.
// Depends on cbc_pkg for field widths.
`default_nettype none

interface cbc_req_if import cbc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] write_address;
   logic [DATA_W-1:0] write_data;

   modport source (output valid, output write_address, output write_data, input ready);
   modport sink   (input valid, input write_address, input write_data, output ready);
endinterface

`default_nettype wire

>>> design/cbc_rsp_if.sv
// Response channel: bank status beat with valid/ready handshake.
// Depends on cbc_pkg for field widths.
`default_nettype none

interface cbc_rsp_if import cbc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ROM_W-1:0] rom_bank;
   logic [RAM_W-1:0] ram_bank;
   logic             rtc_selected;
   logic             rom_bank_changed;
   logic             ram_bank_changed;
   logic             save_old_ram;
   logic [RAM_W-1:0] old_ram_bank;

   modport source (output valid, output rom_bank, output ram_bank, output rtc_selected,
                   output rom_bank_changed, output ram_bank_changed, output save_old_ram,
                   output old_ram_bank, input ready);
   modport sink   (input valid, input rom_bank, input ram_bank, input rtc_selected,
                   input rom_bank_changed, input ram_bank_changed, input save_old_ram,
                   input old_ram_bank, output ready);
endinterface

`default_nettype wire

>>> design/cartridge_bank_controller.sv
// Cartridge bank controller: each CPU write beat on req_chan updates the
// bank state of the selected controller kind (csr_wr_data: none, MBC1,
// MBC3, MBC5) and yields one status beat on rsp_chan with the mapped ROM
// and RAM banks, the RTC select flag, change flags and the write-back
// request for the old RAM bank. Throughput is one write per cycle unless
// rsp_chan stalls; each write passes the input, then the result register.
// Change the controller kind only while no write is in flight.
// Depends on cbc_pkg, cbc_req_if, cbc_rsp_if, the stage modules and
// assert_macros.svh.
`default_nettype none

module cartridge_bank_controller import cbc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   cbc_req_if.sink         req_chan,
   cbc_rsp_if.source       rsp_chan,
   input  wire logic       csr_wr_en,
   input  wire logic [1:0] csr_wr_data
);

`include "assert_macros.svh"

   kind_type       kind_ff;
   kind_type       kind_in;
   logic           s1_valid;
   req_beat_type   s1_beat;
   logic           can_load;
   logic           advance;
   rsp_beat_type   result;
   bank_state_type state;

   // controller kind register
   always_comb begin
      kind_in = kind_ff;
      if (csr_wr_en) begin
         kind_in = kind_type'(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_NONE;
      end else begin
         kind_ff <= kind_in;
      end
   end

   // move the held write into the result register when there is room
   assign advance = s1_valid && can_load;

   cbc_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .s1_valid (s1_valid),
      .s1_beat  (s1_beat)
   );

   cbc_bank_logic u_bank_logic (
      .clock  (clock),
      .reset  (reset),
      .kind   (kind_ff),
      .fire   (advance),
      .beat   (s1_beat),
      .result (result),
      .state  (state)
   );

   cbc_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .beat     (result),
      .can_load (can_load),
      .rsp_chan (rsp_chan)
   );

   // checks
   `CBC_ASSERT_NOW(a_reset_state, clock, reset, $past(reset),
      (state.current_rom == ROM_RESET) && (state.current_ram == '0) && !state.rtc_flag,
      "bank state not at reset value after reset")
   `CBC_ASSERT_NOW(a_save_needs_switch, clock, reset, rsp_chan.valid && rsp_chan.save_old_ram,
      rsp_chan.ram_bank_changed && !rsp_chan.rtc_selected &&
      (rsp_chan.ram_bank != rsp_chan.old_ram_bank),
      "write-back requested without a RAM bank switch")
   `CBC_ASSERT_NEXT(a_state_holds, clock, reset, !advance, $stable(state),
      "bank state moved without a processed write")
   `CBC_ASSERT_NEXT(a_rom_change_real, clock, reset, advance,
      !rsp_chan.rom_bank_changed || (rsp_chan.rom_bank != $past(state.current_rom)),
      "ROM change flagged for the same bank")

endmodule

`default_nettype wire

>>> design/cbc_in_stage.sv
// Input register of the bank controller: captures one request beat.
// Depends on cbc_pkg and cbc_req_if.
`default_nettype none

module cbc_in_stage import cbc_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   cbc_req_if.sink     req_chan,
   input  wire logic   advance,
   output logic        s1_valid,
   output req_beat_type s1_beat
);

   logic         valid_ff;
   logic         valid_in;
   req_beat_type beat_ff;
   logic         accept;

   // take a beat when empty or when the held beat moves on this cycle
   assign req_chan.ready = !valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold payload; no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         beat_ff.write_address <= req_chan.write_address;
         beat_ff.write_data    <= req_chan.write_data;
      end
   end

   assign s1_valid = valid_ff;
   assign s1_beat  = beat_ff;

endmodule

`default_nettype wire

>>> design/cbc_bank_logic.sv
// Bank select logic and bank state registers of the controller.
// Depends on cbc_pkg.
`default_nettype none

module cbc_bank_logic import cbc_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire kind_type       kind,
   input  wire logic           fire,
   input  wire req_beat_type   beat,
   output rsp_beat_type        result,
   output bank_state_type      state
);

   bank_state_type    st_ff;
   bank_state_type    st_in;
   region_type        region;
   logic [DATA_W-1:0] data;
   logic              rom_req;
   logic [ROM_W-1:0]  rom_sel;
   logic              ram_req;
   logic [RAM_W-1:0]  ram_sel;
   logic              rom_chg;
   logic              ram_chg;
   logic              save;

   assign region = region_type'(beat.write_address[14:13]);
   assign data   = beat.write_data;

   // decode the write per controller kind, then apply bank selects
   always_comb begin
      st_in   = st_ff;
      rom_req = 1'b0;
      rom_sel = '0;
      ram_req = 1'b0;
      ram_sel = '0;
      rom_chg = 1'b0;
      ram_chg = 1'b0;
      save    = 1'b0;

      if (!beat.write_address[ADDR_W-1]) begin
         case (kind)
            KIND_MBC1: begin
               case (region)
                  REG_MODE: begin
                     st_in.banking_mode = data[0];
                  end
                  REG_RAM_SEL: begin
                     if (st_ff.banking_mode) begin
                        ram_req = 1'b1;
                        ram_sel = data[RAM_W-1:0];
                     end else begin
                        st_in.upper_rom_bits = data[1:0];
                     end
                  end
                  REG_ROM_SEL: begin
                     rom_req = 1'b1;
                     rom_sel = {1'b0,
                                (st_ff.banking_mode ? 2'b00 : st_ff.upper_rom_bits),
                                data[4:0]};
                     // bank zero in the low five bits maps to one
                     if (data[4:0] == 5'd0) begin
                        rom_sel[0] = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            KIND_MBC3: begin
               case (region)
                  REG_RAM_SEL: begin
                     if (data <= MBC3_RAM_MAX) begin
                        ram_req = 1'b1;
                        ram_sel = data[RAM_W-1:0];
                     end else begin
                        st_in.rtc_flag = 1'b1;
                     end
                  end
                  REG_ROM_SEL: begin
                     rom_req = 1'b1;
                     rom_sel = {1'b0, data[6:0]};
                     if (data[6:0] == 7'd0) begin
                        rom_sel = ROM_RESET;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            KIND_MBC5: begin
               case (region)
                  REG_MODE, REG_RAM_SEL: begin
                     ram_req = 1'b1;
                     ram_sel = data[RAM_W-1:0];
                  end
                  REG_ROM_SEL: begin
                     rom_req = 1'b1;
                     rom_sel = data;
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end

      // ROM switch: only a different bank counts
      if (rom_req && (rom_sel != st_ff.current_rom)) begin
         st_in.current_rom = rom_sel;
         rom_chg           = 1'b1;
      end

      // RAM switch: write back the old window unless the RTC was mapped
      if (ram_req && (ram_sel != st_ff.current_ram)) begin
         save              = !st_ff.rtc_flag;
         st_in.rtc_flag    = 1'b0;
         st_in.current_ram = ram_sel;
         ram_chg           = 1'b1;
      end
   end

   // advance bank state once per processed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.banking_mode   <= 1'b0;
         st_ff.upper_rom_bits <= 2'b00;
         st_ff.current_rom    <= ROM_RESET;
         st_ff.current_ram    <= '0;
         st_ff.rtc_flag       <= 1'b0;
      end else if (fire) begin
         st_ff <= st_in;
      end
   end

   assign result.rom_bank         = st_in.current_rom;
   assign result.ram_bank         = st_in.current_ram;
   assign result.rtc_selected     = st_in.rtc_flag;
   assign result.rom_bank_changed = rom_chg;
   assign result.ram_bank_changed = ram_chg;
   assign result.save_old_ram     = save;
   assign result.old_ram_bank     = st_ff.current_ram;

   assign state = st_ff;

endmodule

`default_nettype wire

>>> design/cbc_out_stage.sv
// Result register of the bank controller: holds one response beat.
// Depends on cbc_pkg and cbc_rsp_if.
`default_nettype none

module cbc_out_stage import cbc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         load,
   input  wire rsp_beat_type beat,
   output logic              can_load,
   cbc_rsp_if.source         rsp_chan
);

   logic         valid_ff;
   logic         valid_in;
   rsp_beat_type beat_ff;

   // free when empty or when the held beat leaves this cycle
   assign can_load = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff <= beat;
      end
   end

   assign rsp_chan.valid            = valid_ff;
   assign rsp_chan.rom_bank         = beat_ff.rom_bank;
   assign rsp_chan.ram_bank         = beat_ff.ram_bank;
   assign rsp_chan.rtc_selected     = beat_ff.rtc_selected;
   assign rsp_chan.rom_bank_changed = beat_ff.rom_bank_changed;
   assign rsp_chan.ram_bank_changed = beat_ff.ram_bank_changed;
   assign rsp_chan.save_old_ram     = beat_ff.save_old_ram;
   assign rsp_chan.old_ram_bank     = beat_ff.old_ram_bank;

endmodule

`default_nettype wire
